// ----- hdl/bpe_pretokenizer_splitter_assert.svh -----
`ifndef BPE_PRETOKENIZER_SPLITTER_ASSERT_SVH
`define BPE_PRETOKENIZER_SPLITTER_ASSERT_SVH

`ifndef SYNTHESIS

`define BPE_SPLIT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bpe splitter check failed");

`define BPE_SPLIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpe splitter check failed");

`else

`define BPE_SPLIT_ASSERT(lbl, prop)

`define BPE_SPLIT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hdl/bpe_split_pkg.sv -----
package bpe_split_pkg;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_LETTER = 3'd1,
    CLS_DIGIT  = 3'd2,
    CLS_OTHER  = 3'd3,
    CLS_WS     = 3'd4
  } cls_e;

  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_M    = 8'h6d;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_V    = 8'h76;
  localparam logic [7:0] CH_L    = 8'h6c;
  localparam logic [7:0] CH_E    = 8'h65;

  // output queue
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);
  localparam int unsigned MAXRES = 3;

  typedef struct packed {
    logic [2:0][7:0] lab;
    logic [1:0]      cnt;
    cls_e            rc;
    logic            aps;
    logic [1:0]      wsl;
  } st_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       starts_token;
    logic       last_of_text;
  } item_t;

  typedef struct packed {
    item_t [MAXRES-1:0] items;
    logic [1:0]         nres;
    st_t                nxt;
  } step_t;

  function automatic cls_e classify(input logic [7:0] b);
    cls_e cls;
    if (b inside {[8'h41:8'h5a], [8'h61:8'h7a]}) begin
      cls = CLS_LETTER;
    end else if (b inside {[8'h30:8'h39]}) begin
      cls = CLS_DIGIT;
    end else if (b inside {8'h20, [8'h09:8'h0d]}) begin
      cls = CLS_WS;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

// ----- hdl/bpe_split_if.sv -----
interface bpe_split_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface bpe_split_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       starts_token;
  logic       last_of_text;

  modport source (output valid, output out_byte, output starts_token, output last_of_text,
                  input ready);
  modport sink (input valid, input out_byte, input starts_token, input last_of_text,
                output ready);
endinterface

// ----- hdl/bpe_pretokenizer_splitter.sv -----
// Byte-level pretokenizer splitter: takes one text byte per cycle and returns every byte
// once, in order, with a token-start flag and the end-of-text flag. A byte is held in the
// input register, is decided there against the held lookahead bytes and goes to an
// eight-entry output queue. A whitespace byte waits for one more byte, an apostrophe at a
// token start for up to two; the final byte of a text flushes everything held, so a burst
// of up to three results can follow one input. Input rate is one byte per cycle and is
// throttled only when the output queue has fewer than three free entries.
`include "bpe_pretokenizer_splitter_assert.svh"

module bpe_pretokenizer_splitter (
  input logic               clk_i,
  input logic               rst_ni,
  bpe_split_in_if.sink      in_i,
  bpe_split_out_if.source   out_o
);
  import bpe_split_pkg::*;

  logic           in_valid_q;
  logic [7:0]     in_byte_q;
  logic           in_fin_q;
  st_t            st_q;
  step_t          res;
  logic           advance;
  logic           in_take;
  logic [QCW-1:0] q_cnt;
  item_t          head;

  bpe_split_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .fin_i  (in_fin_q),
    .res_o  (res)
  );

  assign advance    = in_valid_q && (q_cnt <= QCW'(QDEPTH - MAXRES));
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        st_q <= res.nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_i.text_byte;
      in_fin_q  <= in_i.end_of_text;
    end
  end

  bpe_split_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .items_i    (res.items),
    .push_cnt_i (advance ? res.nres : 2'd0),
    .pop_i      (out_o.valid && out_o.ready),
    .count_o    (q_cnt),
    .head_o     (head)
  );

  assign out_o.valid        = (q_cnt != '0);
  assign out_o.out_byte     = head.out_byte;
  assign out_o.starts_token = head.starts_token;
  assign out_o.last_of_text = head.last_of_text;

  `BPE_SPLIT_ASSERT(a_la_cnt, st_q.cnt != 2'd3)
  `BPE_SPLIT_ASSERT(a_ws_sat, st_q.wsl != 2'd3)
  `BPE_SPLIT_ASSERT(a_q_bound, q_cnt <= QCW'(QDEPTH))
  `BPE_SPLIT_ASSERT_NEXT(a_fin_clear, advance && in_fin_q, st_q.cnt == 2'd0 && !st_q.aps)

endmodule

// ----- hdl/bpe_split_step.sv -----
module bpe_split_step (
  input  bpe_split_pkg::st_t   st_i,
  input  logic [7:0]           byte_i,
  input  logic                 fin_i,
  output bpe_split_pkg::step_t res_o
);
  import bpe_split_pkg::*;

  always_comb begin
    logic [5:0][7:0] c;
    logic [1:0]      cnt;
    logic [1:0]      n;
    logic [1:0]      p;
    logic [1:0]      k;
    logic [1:0]      used;
    logic [1:0]      clen;
    logic [2:0]      starts;
    logic [7:0]      h;
    logic [7:0]      f0;
    logic [7:0]      f1;
    logic [7:0]      need;
    logic            stop;
    logic            s;
    logic            nonws;
    logic            cwait;
    cls_e            cls;
    cls_e            rc;
    logic            aps;
    logic [1:0]      wsl;

    cnt = (st_i.cnt > 2'd2) ? 2'd2 : st_i.cnt;
    n   = cnt + 2'd1;
    c   = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < cnt) begin
        c[i] = st_i.lab[i];
      end else if (2'(i) == cnt) begin
        c[i] = byte_i;
      end
    end
    rc     = st_i.rc;
    aps    = st_i.aps;
    wsl    = st_i.wsl;
    starts = '0;
    p      = '0;
    stop   = 1'b0;

    for (int it = 0; it < MAXRES; it++) begin
      h     = c[{1'b0, p}];
      f0    = c[3'(p) + 3'd1];
      f1    = c[3'(p) + 3'd2];
      cls   = classify(h);
      k     = n - 2'd1 - p;
      used  = '0;
      s     = 1'b0;
      nonws = 1'b0;
      cwait = 1'b0;
      clen  = '0;
      need  = CH_E;
      if (!stop && (p < n)) begin
        if (aps) begin
          // byte right after a prefix space joins it
          aps  = 1'b0;
          wsl  = '0;
          rc   = cls;
          s    = 1'b0;
          used = 2'd1;
        end else if (cls == CLS_WS) begin
          if (!((k == 2'd0) && !fin_i)) begin
            nonws = (k != 2'd0) && (classify(f0) != CLS_WS);
            s     = (wsl == 2'd0) || nonws;
            if (nonws) begin
              aps = 1'b1;
              wsl = '0;
              rc  = CLS_NONE;
            end else begin
              wsl = (wsl < 2'd2) ? wsl + 2'd1 : 2'd2;
              rc  = CLS_WS;
            end
            used = 2'd1;
          end
        end else if (rc == cls) begin
          wsl  = '0;
          s    = 1'b0;
          used = 2'd1;
        end else begin
          if (h == CH_APOS) begin
            if (k == 2'd0) begin
              cwait = !fin_i;
            end else if (f0 inside {CH_S, CH_T, CH_M, CH_D}) begin
              clen = 2'd2;
            end else if (f0 inside {CH_R, CH_V, CH_L}) begin
              need = (f0 == CH_L) ? CH_L : CH_E;
              if (k < 2'd2) begin
                cwait = !fin_i;
              end else if (f1 == need) begin
                clen = 2'd3;
              end
            end
          end
          if (!cwait) begin
            wsl  = '0;
            s    = 1'b1;
            if (clen != 2'd0) begin
              rc   = CLS_NONE;
              used = clen;
            end else begin
              rc   = cls;
              used = 2'd1;
            end
          end
        end
        if (used == 2'd0) begin
          stop = 1'b1;
        end else begin
          starts[p] = s;
          p         = p + used;
        end
      end
    end

    for (int j = 0; j < MAXRES; j++) begin
      res_o.items[j].out_byte     = c[j];
      res_o.items[j].starts_token = starts[j];
      res_o.items[j].last_of_text = fin_i && (2'(j) == (n - 2'd1));
    end
    res_o.nres = p;

    for (int i = 0; i < 3; i++) begin
      res_o.nxt.lab[i] = c[3'(p) + 3'(i)];
    end
    if (fin_i) begin
      res_o.nxt.cnt = '0;
      res_o.nxt.rc  = CLS_NONE;
      res_o.nxt.aps = 1'b0;
      res_o.nxt.wsl = '0;
    end else begin
      res_o.nxt.cnt = n - p;
      res_o.nxt.rc  = rc;
      res_o.nxt.aps = aps;
      res_o.nxt.wsl = wsl;
    end
  end

endmodule

// ----- hdl/bpe_split_fifo.sv -----
module bpe_split_fifo (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  bpe_split_pkg::item_t [bpe_split_pkg::MAXRES-1:0] items_i,
  input  logic [1:0]                                     push_cnt_i,
  input  logic                                           pop_i,
  output logic [bpe_split_pkg::QCW-1:0]                  count_o,
  output bpe_split_pkg::item_t                           head_o
);
  import bpe_split_pkg::*;

  item_t            mem_q [QDEPTH];
  logic [QAW-1:0]   wr_q, wr_d;
  logic [QAW-1:0]   rd_q, rd_d;
  logic [QCW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q + QAW'(push_cnt_i);
    rd_d  = rd_q + QAW'(pop_i);
    cnt_d = cnt_q + QCW'(push_cnt_i) - QCW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAXRES; j++) begin
      if (2'(j) < push_cnt_i) begin
        mem_q[wr_q + QAW'(j)] <= items_i[j];
      end
    end
  end

  assign count_o = cnt_q;
  assign head_o  = mem_q[rd_q];

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import bpe_split_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 150;
  localparam int unsigned MAX_GAP     = 14;
  localparam int unsigned DRAIN_WAIT  = 16;

  typedef struct packed {
    logic [7:0] value;
    logic       eot;
  } text_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       send_valid = 1'b0;
  logic [7:0] send_value = 8'h00;
  logic       send_eot   = 1'b0;
  logic       take_ready = 1'b0;

  bpe_split_in_if  in_bus ();
  bpe_split_out_if out_bus ();

  assign in_bus.valid       = send_valid;
  assign in_bus.text_byte   = send_value;
  assign in_bus.end_of_text = send_eot;
  assign out_bus.ready      = take_ready;

  bpe_pretokenizer_splitter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_req_t   text_todo[$];
  item_t       tagged_due[$];
  logic [7:0]  text_draft[$];
  string       punct_marks = "!#$%&()*+,-./:;<=>?@[]^_{|}~";

  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          hold_req;
  bit          hold_done;
  bit          in_took;
  bit          out_took;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned hold_left;
  int unsigned errors;
  int unsigned bytes_queued;
  int unsigned bytes_in;
  int unsigned texts_in;
  int unsigned bytes_out;
  int unsigned starts_out;
  int unsigned cycles;

  // splitter state as the block should hold it
  logic [7:0]  held[3];
  int unsigned held_n;
  cls_e        run_cls = CLS_NONE;
  bit          pfx_pending;
  int unsigned ws_len;

  function automatic cls_e byte_class(logic [7:0] b);
    if ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a)) return CLS_LETTER;
    if (b >= 8'h30 && b <= 8'h39) return CLS_DIGIT;
    if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0d)) return CLS_WS;
    return CLS_OTHER;
  endfunction

  // bytes taken by a contraction at the head, -1 while undecided
  function automatic int apos_len(bit fin);
    int unsigned k;
    logic [7:0]  need;
    k = held_n - 1;
    if (k == 0) return fin ? 0 : -1;
    case (held[1])
      CH_S, CH_T, CH_M, CH_D: return 2;
      CH_R, CH_V: need = CH_E;
      CH_L: need = CH_L;
      default: return 0;
    endcase
    if (k < 2) return fin ? 0 : -1;
    return (held[2] == need) ? 3 : 0;
  endfunction

  function automatic int settle_head(bit fin, output bit starts);
    logic [7:0]  c;
    int unsigned k;
    cls_e        cls;
    bit          nonws;
    int          m;
    c = held[0];
    k = held_n - 1;
    cls = byte_class(c);
    starts = 1'b0;
    if (pfx_pending) begin
      pfx_pending = 1'b0;
      ws_len = 0;
      run_cls = cls;
      return 1;
    end
    if (cls == CLS_WS) begin
      if (k == 0 && !fin) return 0;
      nonws = (k > 0) && (byte_class(held[1]) != CLS_WS);
      starts = (ws_len == 0) || nonws;
      if (nonws) begin
        pfx_pending = 1'b1;
        ws_len = 0;
        run_cls = CLS_NONE;
      end else begin
        if (ws_len < 2) ws_len++;
        run_cls = CLS_WS;
      end
      return 1;
    end
    if (run_cls == cls) begin
      ws_len = 0;
      return 1;
    end
    if (c == CH_APOS) begin
      m = apos_len(fin);
      if (m < 0) return 0;
      if (m > 0) begin
        ws_len = 0;
        run_cls = CLS_NONE;
        starts = 1'b1;
        return m;
      end
    end
    ws_len = 0;
    run_cls = cls;
    starts = 1'b1;
    return 1;
  endfunction

  task automatic tag_text_byte(logic [7:0] b, bit fin);
    int    used;
    bit    starts;
    item_t r;
    held[held_n] = b;
    held_n++;
    while (held_n > 0) begin
      used = settle_head(fin, starts);
      if (used == 0) break;
      for (int t = 0; t < used; t++) begin
        r.out_byte     = held[t];
        r.starts_token = (t == 0) && starts;
        r.last_of_text = fin && (t == held_n - 1);
        tagged_due = {tagged_due, r};
      end
      for (int t = 0; t + used < held_n; t++) held[t] = held[t + used];
      held_n -= used;
    end
    if (fin) begin
      held_n = 0;
      run_cls = CLS_NONE;
      pfx_pending = 1'b0;
      ws_len = 0;
    end
  endtask

  function automatic int unsigned draw_gap(bit en);
    return en ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  always @(posedge clk_i) begin : monitor
    item_t want;
    if (rst_ni) begin
      in_took  <= in_bus.valid && in_bus.ready;
      out_took <= out_bus.valid && out_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        bytes_in++;
        if (in_bus.end_of_text) texts_in++;
        tag_text_byte(in_bus.text_byte, in_bus.end_of_text);
      end
      if (out_bus.valid && out_bus.ready) begin
        bytes_out++;
        if (out_bus.starts_token) starts_out++;
        if (tagged_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got byte %h start %b last %b",
                   $time, out_bus.out_byte, out_bus.starts_token, out_bus.last_of_text);
        end else begin
          want = tagged_due.pop_front();
          if (want.out_byte !== out_bus.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %h, got %h",
                     $time, want.out_byte, out_bus.out_byte);
          end
          if (want.starts_token !== out_bus.starts_token) begin
            errors++;
            $display("%0t: starts_token of byte %h expected %b, got %b",
                     $time, want.out_byte, want.starts_token, out_bus.starts_token);
          end
          if (want.last_of_text !== out_bus.last_of_text) begin
            errors++;
            $display("%0t: last_of_text of byte %h expected %b, got %b",
                     $time, want.out_byte, want.last_of_text, out_bus.last_of_text);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin : driver
    text_req_t req;
    if (rst_ni && (!send_valid || in_took)) begin
      if (send_valid) tx_gap = draw_gap(tx_idle_en);
      if (tx_gap > 0) begin
        tx_gap--;
        send_valid <= 1'b0;
      end else if (text_todo.size() > 0) begin
        req = text_todo.pop_front();
        send_valid <= 1'b1;
        send_value <= req.value;
        send_eot   <= req.eot;
      end else begin
        send_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if (out_took) rx_gap = draw_gap(rx_idle_en);
      if (hold_left > 0) begin
        hold_left--;
        take_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD - 1;
        hold_done = 1'b1;
        take_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL bpe_pretokenizer_splitter");
      $finish;
    end
  end

  task automatic push_req(logic [7:0] b, bit eot);
    text_req_t req;
    req.value = b;
    req.eot   = eot;
    text_todo = {text_todo, req};
    bytes_queued++;
  endtask

  task automatic draft_add(logic [7:0] b);
    text_draft = {text_draft, b};
  endtask

  task automatic send_text(string s, bit eot_last);
    for (int i = 0; i < s.len(); i++) push_req(s[i], eot_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 2) != 0) return 8'(8'h61 + $urandom_range(0, 25));
    return 8'(8'h41 + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_space();
    if ($urandom_range(0, 5) == 5) return 8'h20;
    return 8'(8'h09 + $urandom_range(0, 4));
  endfunction

  task automatic add_suffix();
    case ($urandom_range(0, 9))
      0: draft_add(CH_S);
      1: draft_add(CH_T);
      2: draft_add(CH_M);
      3: draft_add(CH_D);
      4: begin
        draft_add(CH_R);
        draft_add(CH_E);
      end
      5: begin
        draft_add(CH_V);
        draft_add(CH_E);
      end
      6: begin
        draft_add(CH_L);
        draft_add(CH_L);
      end
      7: draft_add(8'(rand_letter() & 8'hdf));
      8: begin
        case ($urandom_range(0, 2))
          0: draft_add(CH_R);
          1: draft_add(CH_V);
          default: draft_add(CH_L);
        endcase
        draft_add(rand_letter());
      end
      default: ;
    endcase
  endtask

  task automatic add_fragment();
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(1, 4)) draft_add(rand_letter());
      1: repeat ($urandom_range(1, 3)) draft_add(8'(8'h30 + $urandom_range(0, 9)));
      2: repeat ($urandom_range(1, 3)) draft_add(rand_space());
      3, 4: begin
        draft_add(CH_APOS);
        add_suffix();
      end
      5: draft_add(punct_marks[$urandom_range(0, punct_marks.len() - 1)]);
      6: draft_add(8'($urandom_range(0, 255)));
      7: draft_add(8'($urandom_range(128, 255)));
      8: draft_add(8'h20);
      default: draft_add(CH_APOS);
    endcase
  endtask

  task automatic queue_text(bit tidy);
    int unsigned goal;
    goal = tidy ? $urandom_range(1, 16) : $urandom_range(1, 8);
    text_draft.delete();
    while (text_draft.size() < goal) begin
      if (tidy) add_fragment();
      else draft_add(8'($urandom_range(0, 255)));
    end
    // cut some texts short so they end inside a contraction or run
    if (tidy && $urandom_range(0, 3) == 0) goal = $urandom_range(1, text_draft.size());
    else goal = text_draft.size();
    for (int i = 0; i < goal; i++) push_req(text_draft[i], i == goal - 1);
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_queued + count;
    while (bytes_queued < stop_at) queue_text($urandom_range(0, 9) != 0);
  endtask

  task automatic wait_drained();
    while (!(bytes_in == bytes_queued && tagged_due.size() == 0)) begin
      @(negedge clk_i);
      #1;
    end
  endtask

  task automatic set_idling(bit tx_en, bit rx_en);
    tx_idle_en = tx_en;
    rx_idle_en = rx_en;
  endtask

  initial begin : stimulus
    held_n = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    #1 rst_ni = 1'b1;

    set_idling(1'b1, 1'b1);
    send_text("a'sb're'T", 1'b1);
    send_text("9'r", 1'b1);
    push_req(8'h00, 1'b0);
    send_text("  'm\t", 1'b0);
    push_req(8'hff, 1'b0);
    push_req(8'h0d, 1'b1);
    send_text("'", 1'b1);
    send_text("'d'l", 1'b1);
    wait_drained();

    queue_random(130);
    wait_drained();

    // receiver stalls while requests keep coming back to back
    set_idling(1'b0, 1'b0);
    hold_req = 1'b1;
    queue_random(50);
    wait_drained();

    queue_random(90);
    set_idling(1'b1, 1'b0);
    queue_random(55);
    wait_drained();
    set_idling(1'b0, 1'b1);
    queue_random(55);
    wait_drained();
    set_idling(1'b1, 1'b1);
    queue_random(55);

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("run covered %0d text bytes in %0d texts, with idles, a long output stall",
             bytes_in, texts_in);
    $display("and %0d checked results, %0d of them token starts", bytes_out, starts_out);
    if (errors == 0 && tagged_due.size() == 0) begin
      $display("PASS bpe_pretokenizer_splitter");
    end else begin
      $display("FAIL bpe_pretokenizer_splitter");
    end
    $finish;
  end

endmodule
